// ----- design/bsr_pkg.sv -----
// Shared types, operation and status codes, and controller command encodings.
`timescale 1ns / 1ps
package bsr_pkg;

	localparam int unsigned DEPTH_DEF = 16;
	localparam int unsigned OP_W      = 3;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned ROT_W     = 5;
	localparam int unsigned CAP_W     = 5;
	localparam int unsigned STS_W     = 2;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic [OP_W-1:0] OP_PUSH     = 3'd0;
	localparam logic [OP_W-1:0] OP_POP      = 3'd1;
	localparam logic [OP_W-1:0] OP_PEEK     = 3'd2;
	localparam logic [OP_W-1:0] OP_DUP      = 3'd3;
	localparam logic [OP_W-1:0] OP_ROT_UP   = 3'd4;
	localparam logic [OP_W-1:0] OP_ROT_DOWN = 3'd5;
	localparam logic [OP_W-1:0] OP_PRINT    = 3'd6;

	localparam logic [STS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STS_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STS_W-1:0] ST_EMPTY    = 2'd2;
	localparam logic [STS_W-1:0] ST_BADCOUNT = 2'd3;

	// RAM write source select
	localparam int unsigned WR_SEL_W = 3;
	localparam logic [WR_SEL_W-1:0] WR_NONE = 3'd0;
	localparam logic [WR_SEL_W-1:0] WR_PUSH = 3'd1;
	localparam logic [WR_SEL_W-1:0] WR_DUP  = 3'd2;
	localparam logic [WR_SEL_W-1:0] WR_MOVE = 3'd3;
	localparam logic [WR_SEL_W-1:0] WR_TMP  = 3'd4;

	// RAM read address select
	localparam int unsigned RD_SEL_W = 2;
	localparam logic [RD_SEL_W-1:0] RD_NONE  = 2'd0;
	localparam logic [RD_SEL_W-1:0] RD_TOP   = 2'd1;
	localparam logic [RD_SEL_W-1:0] RD_START = 2'd2;
	localparam logic [RD_SEL_W-1:0] RD_NEXT  = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [BYTE_W-1:0] push_byte;
		logic [ROT_W-1:0]  rotate_count;
	} req_t;

	typedef struct packed {
		logic [STS_W-1:0]  status;
		logic [BYTE_W-1:0] byte_out;
		logic              byte_valid;
		logic              last;
	} rsp_t;

	typedef struct packed {
		logic                load;
		logic                cnt_inc;
		logic                cnt_dec;
		logic                tmp_ld;
		logic                emit;
		logic                emit_byte;
		logic                emit_last;
		logic [STS_W-1:0]    emit_status;
		logic [WR_SEL_W-1:0] wr_sel;
		logic [RD_SEL_W-1:0] rd_sel;
	} cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            empty;
		logic            full;
		logic            bad;
		logic            no_move;
		logic            at_end;
		logic            out_free;
	} sts_t;

endpackage

// ----- design/bsr_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module bsr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- design/bsr_dpath.sv -----
// Datapath: stack count, capacity register, entry RAM, walk pointer and result register.
`timescale 1ns / 1ps
module bsr_dpath #(
	parameter int unsigned DEPTH = bsr_pkg::DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  bsr_pkg::req_t            req,
	input  logic                     cfg_we,
	input  logic [bsr_pkg::CAP_W-1:0] cfg_wdata,
	input  bsr_pkg::cmd_t            cmd,
	output bsr_pkg::sts_t            sts,
	output logic                     rsp_valid,
	input  logic                     rsp_ready,
	output bsr_pkg::rsp_t            rsp
);
	import bsr_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned MW = (CW > ROT_W) ? CW : ROT_W;

	logic [OP_W-1:0]   op_q;
	logic [BYTE_W-1:0] byte_q;
	logic [ROT_W-1:0]  n_q;
	logic [CW-1:0]     cnt_q;
	logic [CAP_W-1:0]  cap_q;
	logic [AW-1:0]     ptr_q;
	logic [BYTE_W-1:0] tmp_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic [MW-1:0]     cnt_m, cap_m, n_m, dep_m, lo_m;
	logic [AW-1:0]     top_a, lo_a, start_a, end_a, next_a, mv_a;
	logic [AW-1:0]     rd_addr, wr_addr;
	logic [BYTE_W-1:0] wr_data, rd_data;
	logic              rd_en, wr_en, dir_up;

	assign cnt_m = MW'(cnt_q);
	assign cap_m = MW'(cap_q);
	assign n_m   = MW'(n_q);
	assign dep_m = MW'(DEPTH);
	assign lo_m  = cnt_m - n_m;

	assign top_a  = AW'(cnt_q - CW'(1));
	assign lo_a   = AW'(lo_m);
	assign dir_up = (op_q != OP_ROT_DOWN);
	assign next_a = dir_up ? (ptr_q - AW'(1)) : (ptr_q + AW'(1));
	assign mv_a   = dir_up ? (ptr_q + AW'(1)) : (ptr_q - AW'(1));

	always_comb begin
		start_a = top_a;
		end_a   = '0;
		if (op_q == OP_ROT_DOWN) begin
			start_a = lo_a;
			end_a   = top_a;
		end else if (op_q == OP_ROT_UP) begin
			end_a   = lo_a;
		end
	end

	// read address decode
	always_comb begin
		rd_en   = 1'b1;
		rd_addr = top_a;
		unique case (cmd.rd_sel)
			RD_TOP:   rd_addr = top_a;
			RD_START: rd_addr = start_a;
			RD_NEXT:  rd_addr = next_a;
			default:  rd_en   = 1'b0;
		endcase
	end

	// write source decode
	always_comb begin
		wr_en   = 1'b1;
		wr_addr = AW'(cnt_q);
		wr_data = byte_q;
		unique case (cmd.wr_sel)
			WR_PUSH: begin
				wr_addr = AW'(cnt_q);
				wr_data = byte_q;
			end
			WR_DUP: begin
				wr_addr = AW'(cnt_q);
				wr_data = rd_data;
			end
			WR_MOVE: begin
				wr_addr = mv_a;
				wr_data = rd_data;
			end
			WR_TMP: begin
				wr_addr = ptr_q;
				wr_data = tmp_q;
			end
			default: wr_en = 1'b0;
		endcase
	end

	bsr_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			cap_q       <= CAP_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (cmd.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= req.operation;
			byte_q <= req.push_byte;
			n_q    <= req.rotate_count;
		end
		if (rd_en) begin
			ptr_q <= rd_addr;
		end
		if (cmd.tmp_ld) begin
			tmp_q <= rd_data;
		end
		if (cmd.emit) begin
			rsp_q.status     <= cmd.emit_status;
			rsp_q.byte_out   <= cmd.emit_byte ? rd_data : '0;
			rsp_q.byte_valid <= cmd.emit_byte;
			rsp_q.last       <= cmd.emit_last;
		end
	end

	assign sts.op       = op_q;
	assign sts.empty    = (cnt_q == '0);
	assign sts.full     = (cnt_m >= cap_m) || (cnt_m >= dep_m);
	assign sts.bad      = (n_m > cnt_m);
	assign sts.no_move  = (n_q < ROT_W'(2));
	assign sts.at_end   = (ptr_q == end_a);
	assign sts.out_free = !rsp_valid_q || rsp_ready;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- design/bsr_ctrl.sv -----
// Controller: sequences each operation through the datapath.
`timescale 1ns / 1ps
module bsr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  bsr_pkg::sts_t sts,
	output bsr_pkg::cmd_t cmd
);
	import bsr_pkg::*;

	localparam logic [2:0] S_IDLE      = 3'd0;
	localparam logic [2:0] S_DISP      = 3'd1;
	localparam logic [2:0] S_PEEK      = 3'd2;
	localparam logic [2:0] S_DUP       = 3'd3;
	localparam logic [2:0] S_PRINT     = 3'd4;
	localparam logic [2:0] S_ROT_FIRST = 3'd5;
	localparam logic [2:0] S_ROT_MOVE  = 3'd6;
	localparam logic [2:0] S_ROT_LAST  = 3'd7;

	logic [2:0] state_q, state_d;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_d         = state_q;
		cmd             = '0;
		cmd.emit_last   = 1'b1;
		cmd.emit_status = ST_OK;
		cmd.wr_sel      = WR_NONE;
		cmd.rd_sel      = RD_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				// hold until the result register can take a beat
				if (sts.out_free) begin
					state_d = S_IDLE;
					unique case (sts.op) inside
						OP_PUSH: begin
							cmd.emit = 1'b1;
							if (sts.full) begin
								cmd.emit_status = ST_FULL;
							end else begin
								cmd.wr_sel  = WR_PUSH;
								cmd.cnt_inc = 1'b1;
							end
						end
						OP_POP: begin
							cmd.emit = 1'b1;
							if (sts.empty) begin
								cmd.emit_status = ST_EMPTY;
							end else begin
								cmd.cnt_dec = 1'b1;
							end
						end
						OP_PEEK, OP_DUP, OP_PRINT: begin
							if (sts.empty) begin
								cmd.emit        = 1'b1;
								cmd.emit_status = ST_EMPTY;
							end else if (sts.op == OP_DUP && sts.full) begin
								cmd.emit        = 1'b1;
								cmd.emit_status = ST_FULL;
							end else begin
								cmd.rd_sel = RD_TOP;
								if (sts.op == OP_PEEK) begin
									state_d = S_PEEK;
								end else if (sts.op == OP_DUP) begin
									state_d = S_DUP;
								end else begin
									state_d = S_PRINT;
								end
							end
						end
						OP_ROT_UP, OP_ROT_DOWN: begin
							if (sts.bad) begin
								cmd.emit        = 1'b1;
								cmd.emit_status = ST_BADCOUNT;
							end else if (sts.no_move) begin
								cmd.emit = 1'b1;
							end else begin
								cmd.rd_sel = RD_START;
								state_d    = S_ROT_FIRST;
							end
						end
						default: begin
							cmd.emit = 1'b1;
						end
					endcase
				end
			end
			S_PEEK: begin
				cmd.emit      = 1'b1;
				cmd.emit_byte = 1'b1;
				state_d       = S_IDLE;
			end
			S_DUP: begin
				cmd.wr_sel  = WR_DUP;
				cmd.cnt_inc = 1'b1;
				cmd.emit    = 1'b1;
				state_d     = S_IDLE;
			end
			S_PRINT: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_byte = 1'b1;
					cmd.emit_last = sts.at_end;
					if (sts.at_end) begin
						state_d = S_IDLE;
					end else begin
						cmd.rd_sel = RD_NEXT;
					end
				end
			end
			S_ROT_FIRST: begin
				cmd.tmp_ld = 1'b1;
				cmd.rd_sel = RD_NEXT;
				state_d    = S_ROT_MOVE;
			end
			S_ROT_MOVE: begin
				cmd.wr_sel = WR_MOVE;
				if (sts.at_end) begin
					state_d = S_ROT_LAST;
				end else begin
					cmd.rd_sel = RD_NEXT;
				end
			end
			S_ROT_LAST: begin
				cmd.wr_sel = WR_TMP;
				cmd.emit   = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- design/byte_stack_with_rotate_unit.sv -----
// Top level of the byte stack with rotate: controller plus datapath.
`timescale 1ns / 1ps
//
//  channel  | signals                          | direction | beat
//  ---------+----------------------------------+-----------+-------------------------------
//  request  | req_valid, req_ready, req        | in        | one operation
//  response | rsp_valid, rsp_ready, rsp        | out       | one result (print: one per entry)
//  config   | cfg_we, cfg_wdata                | in        | capacity write, no wait
//
//  Push, pop, errors and unused codes end at dispatch; peek and dup read the top first; a
//  rotate saves its start entry, moves the rest and writes it back. The entry RAM has one
//  write and one registered read port, so walks move one entry per cycle while not stalled.
//  Reset clears the count (stack empty) and sets capacity to 16; entries need no clear.
//  A stalled response holds the controller; print resumes reading once the beat is taken.
//
module byte_stack_with_rotate_unit #(
	parameter int unsigned DEPTH = bsr_pkg::DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  bsr_pkg::req_t             req,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output bsr_pkg::rsp_t             rsp,
	input  logic                      cfg_we,
	input  logic [bsr_pkg::CAP_W-1:0] cfg_wdata
);
	import bsr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequence operations; a request is taken only when the controller is idle
	bsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// count, capacity, entry RAM and the result register that decouples the response side
	bsr_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
